@@ hdl/zwbe_pkg.sv @@
// Shared types and constants for the zero-word bitmap expander.
// No dependencies; imported by zwbe_step and zero_word_bitmap_expander.
package zwbe_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned TAG_W  = 32;
  // Position counter must hold the block size itself (up to 32).
  localparam int unsigned POS_W  = 6;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [TAG_W-1:0]  tag_t;
  typedef logic [POS_W-1:0]  pos_t;

  // Result of one pass through the shared position unit.
  typedef struct packed {
    pos_t pos_q;   // position under test
    logic run_on;  // position is inside the block and its tag bit is clear
  } step_res_t;

endpackage

@@ hdl/zero_word_bitmap_expander.sv @@
// Top level of the zero-word bitmap expander.
// Depends on zwbe_pkg and zwbe_step.
//
// Expands a stream of 32-bit words in which each block opens with a tag word
// whose set bits mark literal positions and whose clear bits stand for zero
// words. The block delivers at most one result per clock cycle while the
// result channel is not stalled, through a registered output stage, stepping
// the block position with a single shared increment and tag-bit test unit.
// An input word is held off while the results it causes are emitted. A
// literal word is emitted first, followed by the zero words it causes; a
// tag word gives no result of its own, so a tag word whose first bit is set
// gives no result at all. out_last marks the final result caused by each
// input word; the word marked by in_last ends the stream and returns the
// block to awaiting a tag once its run of zeros has been delivered.
module zero_word_bitmap_expander #(
  parameter int unsigned BLOCK_WORDS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  zwbe_pkg::word_t in_word,
  input  logic            in_last,
  output logic            out_valid,
  input  logic            out_ready,
  output zwbe_pkg::word_t out_word,
  output logic            out_last
);
  import zwbe_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t    state_r, state_nxt;
  logic      awaiting_r, awaiting_nxt;
  tag_t      tag_r, tag_nxt;
  pos_t      pos_r, pos_nxt;
  logic      last_r, last_nxt;
  logic      out_valid_r, out_valid_nxt;
  word_t     out_word_r, out_word_nxt;
  logic      out_last_r, out_last_nxt;

  logic      tag_mode;
  logic      slot_free;
  logic      in_fire;
  logic      finish;
  logic      fin_last;
  tag_t      st_tag;
  pos_t      st_pos;
  logic      st_inc;
  step_res_t st_res;

  assign tag_mode  = awaiting_r || (pos_r >= POS_W'(BLOCK_WORDS));
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && slot_free;
  assign in_fire   = in_valid && in_ready;

  // A tag word is tested from position zero; otherwise the next position.
  always_comb begin
    if ((state_r == ST_IDLE) && tag_mode) begin
      st_tag = in_word;
      st_pos = '0;
      st_inc = 1'b0;
    end else begin
      st_tag = tag_r;
      st_pos = pos_r;
      st_inc = 1'b1;
    end
  end

  zwbe_step #(
    .BLOCK_WORDS(BLOCK_WORDS)
  ) u_step (
    .tag (st_tag),
    .pos (st_pos),
    .inc (st_inc),
    .res (st_res)
  );

  always_comb begin
    state_nxt     = state_r;
    awaiting_nxt  = awaiting_r;
    tag_nxt       = tag_r;
    pos_nxt       = pos_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    out_last_nxt  = out_last_r;
    finish        = 1'b0;
    fin_last      = last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          last_nxt = in_last;
          fin_last = in_last;
          if (tag_mode) begin
            tag_nxt      = in_word;
            pos_nxt      = '0;
            awaiting_nxt = 1'b0;
          end else begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = in_word;
            out_last_nxt  = !st_res.run_on;
            pos_nxt       = st_res.pos_q;
          end
          if (st_res.run_on) begin
            state_nxt = ST_RUN;
          end else begin
            finish = 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '0;
          out_last_nxt  = !st_res.run_on;
          pos_nxt       = st_res.pos_q;
          if (!st_res.run_on) begin
            finish    = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // End of the work caused by one input word.
    if (finish) begin
      if (pos_nxt >= POS_W'(BLOCK_WORDS)) begin
        awaiting_nxt = 1'b1;
      end
      if (fin_last) begin
        awaiting_nxt = 1'b1;
        tag_nxt      = '0;
        pos_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      awaiting_r  <= 1'b1;
      tag_r       <= '0;
      pos_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      awaiting_r  <= awaiting_nxt;
      tag_r       <= tag_nxt;
      pos_r       <= pos_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_word_r <= out_word_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_last  = out_last_r;

endmodule

@@ hdl/zwbe_step.sv @@
// Shared position unit: one increment and one tag-bit test per cycle.
// Depends on zwbe_pkg.
module zwbe_step #(
  parameter int unsigned BLOCK_WORDS = 32
) (
  input  zwbe_pkg::tag_t      tag,
  input  zwbe_pkg::pos_t      pos,
  input  logic                inc,
  output zwbe_pkg::step_res_t res
);
  import zwbe_pkg::*;

  pos_t q;

  always_comb begin
    q = pos + {{(POS_W-1){1'b0}}, inc};
    res.pos_q  = q;
    // The low five bits index the tag; the range check guards the index.
    res.run_on = (q < POS_W'(BLOCK_WORDS)) && !tag[q[POS_W-2:0]];
  end

endmodule
